>>> rtl/core/mbps_pkg.sv
// Shared constants and register codes for the masked byte pattern scanner.
package mbps_pkg;

  localparam int PATTERN_MAX_DEF   = 16;
  localparam int OFFSET_BITS_DEF   = 31;
  localparam int REG_PATTERN_BYTES = 16;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int PLEN_W     = 5;
  localparam int CARE_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLEN     = 2'd3;

  localparam logic [CARE_W-1:0] CARE_RESET = 16'hFFFF;
  localparam logic [PLEN_W-1:0] PLEN_RESET = 5'd1;

  // Controls shared by every cell of the match chain.
  typedef struct packed {
    logic       step;   // a byte is taken this cycle
    logic       clear;  // that byte ends the region
    logic [7:0] data;   // the byte itself
  } cell_ctrl_t;

endpackage

>>> rtl/core/mbps_cell.sv
// One match cell: holds "pattern prefix up to this byte matched" and feeds its neighbor.
module mbps_cell
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] pat_byte,
  input  logic       care,
  input  logic       prev_held,
  output logic       hit,
  output logic       held
);

  // Prefix through this cell matches on the incoming byte.
  assign hit = prev_held && (!care || (ctrl.data == pat_byte));

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (ctrl.step) begin
      held <= ctrl.clear ? 1'b0 : hit;
    end
  end

endmodule

>>> rtl/core/mbps_out_buf.sv
// Two-entry output register with skid slot for scan results.
module mbps_out_buf
  import mbps_pkg::*;
#(
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic              push_found,
  input  logic [DATA_W-1:0] push_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [DATA_W-1:0] out_data
);

  logic              skid_valid;
  logic              skid_found;
  logic [DATA_W-1:0] skid_data;
  logic              pop;

  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_found <= skid_found;
        out_data  <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_found <= push_found;
        skid_data  <= push_data;
      end else begin
        out_found <= push_found;
        out_data  <= push_data;
      end
    end
  end

endmodule

>>> rtl/core/masked_byte_pattern_scan_core.sv
// Masked byte pattern scanner: top level with config registers, match chain and output buffer.
//
// Usage: stream a region into s_* one byte per request (s_tdata[7:0]), with s_tlast
// on its final byte. At most one result per region comes out on m_*: m_tuser = 1 with
// m_tdata holding the start offset of the first match, given on the byte that completes
// it, or m_tuser = 0 with offset 0 on the final byte when nothing matched. Bytes after a
// match give nothing; the final byte always rearms the scan.
// Pattern, care mask and length are written through cfg_we/cfg_index/cfg_data while the
// stream is idle (index 0 pattern bytes 0-7, 1 bytes 8-15, 2 care mask, 3 length).
// Throughput: one byte per cycle while s_tready is high. Each byte advances a row of match
// cells, one cell per pattern byte, each comparing the byte with its own pattern byte in
// the same cycle. A result is registered in the output buffer before it shows on m_*.
// Stall: results sit in an output register backed by one skid slot; s_tready drops only
// while both hold a result and clears the cycle after m_tready takes one.
// Reset (rst, synchronous): config returns to pattern zero, care all set, length 1,
// the scan is armed and the output buffer is empty.
module masked_byte_pattern_scan_core
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int M_DATA_W   = ((OFFSET_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,    // [7:0] data_byte
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,    // [OFFSET_BITS-1:0] match_offset, rest zero
  output logic                  m_tuser,    // [0] found
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CELLS = (PATTERN_MAX < REG_PATTERN_BYTES) ? PATTERN_MAX : REG_PATTERN_BYTES;
  localparam int LEN_W = $clog2(CELLS + 1);
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

  logic [CFG_DATA_W-1:0] pat_low;
  logic [CFG_DATA_W-1:0] pat_high;
  logic [CARE_W-1:0]     care_mask;
  logic [PLEN_W-1:0]     pattern_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low     <= '0;
      pat_high    <= '0;
      care_mask   <= CARE_RESET;
      pattern_len <= PLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT_LOW:  pat_low     <= cfg_data;
        REG_PAT_HIGH: pat_high    <= cfg_data;
        REG_CARE:     care_mask   <= cfg_data[CARE_W-1:0];
        REG_PLEN:     pattern_len <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic [2*CFG_DATA_W-1:0] pat_all;
  logic [LEN_W-1:0]        eff_len;

  assign pat_all = {pat_high, pat_low};

  always_comb begin
    priority if (pattern_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_len > PLEN_W'(CELLS)) begin
      eff_len = LEN_W'(CELLS);
    end else begin
      eff_len = LEN_W'(pattern_len);
    end
  end

  logic       accept;
  logic       buf_ready;
  cell_ctrl_t ctrl;

  assign s_tready   = buf_ready;
  assign accept     = s_tvalid && buf_ready;
  assign ctrl.step  = accept;
  assign ctrl.clear = s_tlast;
  assign ctrl.data  = s_tdata;

  logic [CELLS-1:0] hit;
  logic [CELLS-1:0] held;
  logic [CELLS-1:0] final_cell;

  genvar gi;
  generate
    for (gi = 0; gi < CELLS; gi++) begin : g_cell
      logic prev;
      if (gi == 0) begin : g_head
        assign prev = 1'b1;
      end else begin : g_link
        assign prev = held[gi-1];
      end
      assign final_cell[gi] = (eff_len == LEN_W'(gi + 1));
      mbps_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctrl      (ctrl),
        .pat_byte  (pat_all[gi*8 +: 8]),
        .care      (care_mask[gi]),
        .prev_held (prev),
        .hit       (hit[gi]),
        .held      (held[gi])
      );
    end
  endgenerate

  logic                   reported;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] seen_next;
  logic [OFFSET_BITS-1:0] match_start;
  logic                   match;
  logic                   result;

  assign seen_next   = (bytes_seen == COUNT_MAX) ? bytes_seen : bytes_seen + 1'b1;
  assign match_start = seen_next - OFFSET_BITS'(eff_len);
  assign match       = !reported && |(hit & final_cell);
  assign result      = accept && (match || (s_tlast && !reported));

  always_ff @(posedge clk) begin
    if (rst) begin
      reported   <= 1'b0;
      bytes_seen <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        reported   <= 1'b0;
        bytes_seen <= '0;
      end else begin
        reported   <= reported || match;
        bytes_seen <= seen_next;
      end
    end
  end

  logic [M_DATA_W-1:0] res_data;

  assign res_data = match ? M_DATA_W'(match_start) : '0;

  mbps_out_buf #(
    .DATA_W (M_DATA_W)
  ) u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (result),
    .push_found (match),
    .push_data  (res_data),
    .in_ready   (buf_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_found  (m_tuser),
    .out_data   (m_tdata)
  );

endmodule

>>> rtl/core/mbps_check.sv
// Port-level checks for the masked byte pattern scanner, bound to the top level.
module mbps_check
  import mbps_pkg::*;
#(
  parameter int M_DATA_W = 32
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                s_tlast,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser
);

  // Held result must not change while the receiver stalls.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A not-found result carries offset zero.
  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("not-found result with nonzero offset");

  // Input only backs up when a result is already waiting at the output.
  a_bp: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // Reset leaves the output empty and the input open.
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output not empty after reset");

  // Handshake outputs stay known, and so do the fields of a waiting result.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({m_tvalid, s_tready}) && (!m_tvalid || !$isunknown({m_tuser, m_tdata})))
    else $error("unknown value on output handshake or result");

endmodule

bind masked_byte_pattern_scan_core mbps_check #(
  .M_DATA_W (M_DATA_W)
) u_mbps_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> dv/masked_byte_pattern_scan_core_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the masked byte pattern scanner: predicts each result and compares it.
module masked_byte_pattern_scan_core_checker
  import mbps_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int M_DATA_W    = ((OFFSET_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,    // [7:0] data_byte
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_DATA_W-1:0]   m_tdata,    // [OFFSET_BITS-1:0] match_offset, rest zero
  input  logic                  m_tuser,    // [0] found
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    results
);

  localparam int DEPTH     = PATTERN_MAX_DEF;
  localparam int LEN_CAP   = (PATTERN_MAX_DEF < REG_PATTERN_BYTES) ? PATTERN_MAX_DEF
                                                                   : REG_PATTERN_BYTES;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic                   found;
    logic [OFFSET_BITS-1:0] offset;
  } scan_result_t;

  logic [63:0]            pat_low;
  logic [63:0]            pat_high;
  logic [CARE_W-1:0]      care;
  logic [PLEN_W-1:0]      plen;
  logic [7:0]             window [DEPTH];
  logic [OFFSET_BITS-1:0] seen;
  logic                   reported;
  scan_result_t           expected_q [$];

  function automatic int unsigned used_len();
    int unsigned n;
    n = plen;
    if (n == 0) n = 1;
    if (n > LEN_CAP) n = LEN_CAP;
    return n;
  endfunction

  function automatic logic [7:0] pat_byte(int unsigned i);
    logic [63:0] w;
    w = (i < 8) ? pat_low : pat_high;
    return w[(i % 8) * 8 +: 8];
  endfunction

  task automatic report(input string what);
    // keep the log short on a badly broken run; every mismatch still counts
    if (errors < PRINT_CAP) $display("%0t ns: mismatch: %s", $time, what);
    errors++;
  endtask

  task automatic rearm();
    for (int k = 0; k < DEPTH; k++) window[k] = 8'h00;
    seen     = '0;
    reported = 1'b0;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last_in);
    int unsigned  len;
    logic         hit;
    scan_result_t r;
    len = used_len();
    for (int k = DEPTH - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = b;
    if (seen != '1) seen++;
    // window[0] is the newest byte, so pattern byte 0 sits at window[len-1]
    hit = !reported && (seen >= len);
    for (int i = 0; i < len; i++)
      if (care[i] && window[len-1-i] != pat_byte(i)) hit = 1'b0;
    if (hit) begin
      reported = 1'b1;
      r.found  = 1'b1;
      r.offset = OFFSET_BITS'(seen - len);
      expected_q.push_back(r);
    end else if (last_in && !reported) begin
      r.found  = 1'b0;
      r.offset = '0;
      expected_q.push_back(r);
    end
    if (last_in) rearm();
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      pat_low  = '0;
      pat_high = '0;
      care     = CARE_RESET;
      plen     = PLEN_RESET;
      rearm();
      expected_q.delete();
      errors   = 0;
      results  = 0;
    end else begin
      // the result request is compared before this edge's byte is predicted
      if (m_tvalid && m_tready) begin
        results++;
        if (expected_q.size() == 0) begin
          report($sformatf("result found=%0b offset=%0d with none expected",
                           m_tuser, m_tdata));
        end else begin
          want = expected_q.pop_front();
          if (m_tuser !== want.found)
            report($sformatf("found %0b, expected %0b", m_tuser, want.found));
          if (m_tdata !== M_DATA_W'(want.offset))
            report($sformatf("offset %0d, expected %0d", m_tdata, want.offset));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PAT_LOW:  pat_low  = cfg_data;
          REG_PAT_HIGH: pat_high = cfg_data;
          REG_CARE:     care     = cfg_data[CARE_W-1:0];
          REG_PLEN:     plen     = cfg_data[PLEN_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
    end
    pending = expected_q.size();
  end

endmodule

>>> dv/masked_byte_pattern_scan_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for the masked byte pattern scanner: clock, reset, stimulus and verdict.
module masked_byte_pattern_scan_core_tb;
  import mbps_pkg::*;

  localparam int OFF_W        = OFFSET_BITS_DEF;
  localparam int M_W          = ((OFF_W + 7) / 8) * 8;
  localparam int LEN_CAP      = 16;
  localparam int ITEM_TARGET  = 1200;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {SHAPE_NOISE, SHAPE_HIT, SHAPE_NEAR_MISS, SHAPE_TWO_HITS} region_shape_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = 8'h00;   // [7:0] data_byte
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b1;
  logic [M_W-1:0]        m_tdata;             // [OFF_W-1:0] match_offset, rest zero
  logic                  m_tuser;             // [0] found
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_PAT_LOW;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int errors;
  int pending;
  int results;

  // stimulus-side copy of the settings, used only to plant patterns
  logic [63:0]       sh_low  = '0;
  logic [63:0]       sh_high = '0;
  logic [CARE_W-1:0] sh_care = CARE_RESET;
  logic [PLEN_W-1:0] sh_plen = PLEN_RESET;

  logic [7:0] region_q [$];
  int items_sent  = 0;
  int regions     = 0;
  int cfg_writes  = 0;
  int gap_pct     = 0;
  int stall_pct   = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  masked_byte_pattern_scan_core dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  masked_byte_pattern_scan_core_checker #(.OFFSET_BITS(OFF_W), .M_DATA_W(M_W)) u_checker (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .cfg_we, .cfg_index, .cfg_data,
    .errors, .pending, .results
  );

  // result side: random stall bursts while stall_pct is nonzero
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        m_tready = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        hold = $urandom_range(1, 6) - 1;
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("masked_byte_pattern_scan_core_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int stim_len();
    int n;
    n = sh_plen;
    if (n == 0) n = 1;
    if (n > LEN_CAP) n = LEN_CAP;
    return n;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_PAT_LOW:  sh_low  = val;
      REG_PAT_HIGH: sh_high = val;
      REG_CARE:     sh_care = val[CARE_W-1:0];
      REG_PLEN:     sh_plen = val[PLEN_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // all results in, then idle with s_tvalid low for bytes that produce none
  task automatic settle();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic last_in);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = d;
    s_tlast  = last_in;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic flush_region();
    for (int i = 0; i < region_q.size(); i++)
      send_byte(region_q[i], i == region_q.size() - 1);
    regions++;
  endtask

  // copy the pattern into the region at pos; wildcard bytes get random values
  task automatic plant(input int pos, input bit corrupt);
    int len;
    int cared [$];
    int j;
    len = stim_len();
    for (int k = 0; k < len; k++) begin
      region_q[pos + k] = sh_care[k] ? (k < 8 ? sh_low[k*8 +: 8] : sh_high[(k-8)*8 +: 8])
                                     : 8'($urandom);
      if (sh_care[k]) cared.push_back(k);
    end
    if (corrupt && cared.size() != 0) begin
      j = cared[$urandom_range(0, cared.size() - 1)];
      region_q[pos + j] = region_q[pos + j] ^ 8'($urandom_range(1, 255));
    end
  endtask

  task automatic send_region(input int n, input region_shape_t shape);
    int len;
    len = stim_len();
    region_q.delete();
    for (int i = 0; i < n; i++) region_q.push_back(8'($urandom));
    if (shape != SHAPE_NOISE && n >= len) begin
      plant($urandom_range(0, n - len), shape == SHAPE_NEAR_MISS);
      if (shape == SHAPE_TWO_HITS) plant($urandom_range(0, n - len), 1'b0);
    end
    flush_region();
  endtask

  task automatic random_config();
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    write_reg(REG_PAT_LOW, v);
    case ($urandom_range(0, 3))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    write_reg(REG_PAT_HIGH, v);
    case ($urandom_range(0, 4))
      0:       v = 64'h0;
      1:       v = 64'hFFFF;
      2:       v = 64'($urandom_range(0, 65535) & $urandom_range(0, 65535));
      default: v = 64'($urandom_range(0, 65535));
    endcase
    write_reg(REG_CARE, v);
    case ($urandom_range(0, 6))
      0:       v = 64'd0;
      1:       v = 64'd1;
      2:       v = 64'd16;
      3:       v = 64'($urandom_range(17, 31));
      default: v = 64'($urandom_range(2, 15));
    endcase
    write_reg(REG_PLEN, v);
  endtask

  initial begin
    int            phases;
    int            n;
    int            r;
    region_shape_t shape;

    phases = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // reset settings: single zero byte, no wildcards
    region_q = '{8'h00};
    flush_region();

    settle();
    write_reg(REG_PAT_LOW, 64'h0000_0000_00CC_BBAA);
    write_reg(REG_PLEN, 64'd3);
    region_q = '{8'hAA, 8'hBB};                      // too short to match
    flush_region();
    region_q = '{8'h11, 8'hAA, 8'hBB, 8'hCC, 8'hAA}; // bytes after the hit stay quiet
    flush_region();
    region_q = '{8'hAA, 8'hBB, 8'hCC};               // hit on the final byte
    flush_region();

    // middle byte wildcard, care bits beyond the length set
    settle();
    write_reg(REG_CARE, 64'hFF05);
    region_q = '{8'hAA, 8'h5E, 8'hCC};
    flush_region();

    // length 0 acts as 1 and an empty mask hits at once
    settle();
    write_reg(REG_CARE, 64'h0);
    write_reg(REG_PLEN, 64'd0);
    region_q = '{8'h37, 8'h42};
    flush_region();

    // oversize length clamps to 16; only the end bytes are cared
    settle();
    write_reg(REG_PAT_LOW, '1);
    write_reg(REG_PAT_HIGH, '1);
    write_reg(REG_CARE, 64'h8001);
    write_reg(REG_PLEN, 64'd31);
    region_q.delete();
    region_q.push_back(8'hFF);
    repeat (14) region_q.push_back(8'($urandom));
    region_q.push_back(8'hFF);
    flush_region();

    while (items_sent < ITEM_TARGET) begin
      settle();
      random_config();
      if (items_sent > ITEM_TARGET * 85 / 100 || $urandom_range(0, 3) == 0) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(5, 40);
        stall_pct = $urandom_range(5, 40);
      end
      repeat ($urandom_range(2, 5)) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        r = $urandom_range(0, 9);
        if (r < 5)      shape = SHAPE_HIT;
        else if (r < 7) shape = SHAPE_NEAR_MISS;
        else if (r < 8) shape = SHAPE_TWO_HITS;
        else            shape = SHAPE_NOISE;
        send_region(n, shape);
      end
      phases++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d bytes in %0d regions over %0d random settings, %0d register writes",
             items_sent, regions, phases, cfg_writes);
    $display("checked %0d results, %0d mismatches", results, errors);
    if (errors == 0) begin
      $display("masked_byte_pattern_scan_core_tb passed");
    end else begin
      $display("masked_byte_pattern_scan_core_tb failed");
    end
    $finish;
  end

endmodule
